// ----- design/atdl_pkg.sv -----
// Package for the associative define/lookup table.
// Holds sizes, item and result types, command and status codes, and the
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package atdl_pkg;

    // Table sizing
    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // Port field widths are fixed at 32; stored widths keep the low bits
    localparam int FIELD_BITS = 32;
    localparam int KW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int VW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    // Index into the stores, and a count that can hold ENTRIES itself
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic CMD_DEFINE = 1'b0;
    localparam logic CMD_GET    = 1'b1;

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_APPENDED = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISS     = 2'd3
    } t_status;

    typedef struct packed {
        logic                  cmd;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] value;
    } t_item;

    typedef struct packed {
        t_status               status;
        logic [FIELD_BITS-1:0] read_value;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture the item, restart the scan
        logic rd_en;   // read the next entry
        logic finish;  // write back and present the result
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic empty;     // no entries stored
        logic rd_done;   // every stored entry has been read
        logic hit;       // last entry read matches the key
        logic miss_end;  // last stored entry read and it did not match
    } t_dp_stat;

endpackage

// ----- design/atdl_ctrl.sv -----
// Controller for the associative define/lookup table.
// Sequences load, scan and finish for one item; uses atdl_pkg.
`timescale 1ns / 1ps

module atdl_ctrl
    import atdl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_ctl     o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ctl.load   = 1'b0;
        o_ctl.rd_en  = 1'b0;
        o_ctl.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // stop reading once the match is seen or the entries run out
                o_ctl.rd_en = !i_stat.rd_done && !i_stat.hit;
                if (i_stat.empty || i_stat.hit || i_stat.miss_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- design/atdl_dp.sv -----
// Datapath for the associative define/lookup table: key and value stores,
// scan counters, key compare, write-back and result register; uses atdl_pkg.
`timescale 1ns / 1ps

module atdl_dp
    import atdl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_item    i_item,
    input  t_ctl     i_ctl,
    output t_dp_stat o_stat,
    output logic     o_done,
    output t_result  o_result
);

    logic [KW-1:0] key_mem [ENTRIES];
    logic [VW-1:0] val_mem [ENTRIES];

    // Captured item
    logic          r_cmd;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;

    // Scan state
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_idx;
    logic [IW-1:0] r_q_idx;
    logic          r_q_vld;
    logic [KW-1:0] r_key_q;
    logic [VW-1:0] r_val_q;

    // Result
    logic    r_done;
    t_result r_result;

    logic          hit;
    logic          full;
    logic [CW-1:0] q_next;
    logic          key_we;
    logic          val_we;
    logic [IW-1:0] val_waddr;
    t_result       n_result;

    assign hit    = r_q_vld && (r_key_q == r_key);
    assign full   = (r_count == CW'(ENTRIES));
    assign q_next = CW'(r_q_idx) + CW'(1);

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.rd_done  = (r_rd_idx == r_count);
    assign o_stat.hit      = hit;
    assign o_stat.miss_end = r_q_vld && !hit && (q_next == r_count);

    // Decide the write-back and the answer
    always_comb begin
        key_we              = 1'b0;
        val_we              = 1'b0;
        val_waddr           = r_q_idx;
        n_result.status     = ST_MISS;
        n_result.read_value = '0;
        if (r_cmd == CMD_DEFINE) begin
            if (hit) begin
                val_we          = i_ctl.finish;
                n_result.status = ST_UPDATED;
            end else if (!full) begin
                key_we          = i_ctl.finish;
                val_we          = i_ctl.finish;
                val_waddr       = r_count[IW-1:0];
                n_result.status = ST_APPENDED;
            end
        end else if (hit) begin
            n_result.status     = ST_FOUND;
            n_result.read_value = FIELD_BITS'(r_val_q);
        end
    end

    // Stores: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_count[IW-1:0]] <= r_key;
        end
        if (val_we) begin
            val_mem[val_waddr] <= r_val;
        end
        if (i_ctl.rd_en) begin
            r_key_q <= key_mem[r_rd_idx[IW-1:0]];
            r_val_q <= val_mem[r_rd_idx[IW-1:0]];
            r_q_idx <= r_rd_idx[IW-1:0];
        end
    end

    // Item capture and read address
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_item.cmd;
            r_key    <= i_item.key[KW-1:0];
            r_val    <= i_item.value[VW-1:0];
            r_rd_idx <= '0;
        end else if (i_ctl.rd_en) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
        if (i_ctl.finish) begin
            r_result <= n_result;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_q_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_ctl.finish;
            if (i_ctl.load) begin
                r_q_vld <= 1'b0;
            end else if (i_ctl.rd_en) begin
                r_q_vld <= 1'b1;
            end
            if (key_we) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- design/assoc_table_define_lookup.sv -----
// Associative define/lookup table, linear search in insertion order: top level.
// Depends on atdl_pkg, atdl_ctrl and atdl_dp.
//
// Drive i_start with an item on i_item while o_busy is low; the transfer
// happens on that edge. A define (cmd 0) overwrites the value of the first
// entry whose key matches, or appends a new entry; a define of a new key
// into a full table changes nothing and answers not found. A get (cmd 1)
// returns the value of the first matching entry. Exactly one result per
// item is registered on o_result and held, flagged by o_done for one
// cycle; the receiver cannot stall, so capture it on that cycle. An item
// is handled in order by a load step, a scan that reads stored entries
// until a match or the last entry (the stores have a single registered
// read port, so one key is compared per cycle), a compare of the last read,
// a write-back and the result register. The next start is taken in the
// cycle o_done is high. Keys keep their low KEY_BITS bits and values
// their low VALUE_BITS bits. The entry count resets to zero; the stores
// need no clearing since only entries below the count are ever read.
`timescale 1ns / 1ps

module assoc_table_define_lookup
    import atdl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    t_ctl     ctl;
    t_dp_stat dp_stat;
    logic     busy;

    // Sequence load, scan and write-back
    atdl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    // Hold the stores, compare keys, register the result
    atdl_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_stat   (dp_stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

    assign o_busy = busy;

endmodule
